[rtl/pva_pkg.sv]
// Shared constants, types and codes for the polyphonic voice allocator.
// No dependencies; the rtl/ files other than pva_ram use it by scoped names.
`timescale 1ns / 1ps

package pva_pkg;

    localparam int MAX_VOICES  = 16;
    localparam int VOICE_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W       = $clog2(MAX_VOICES + 1);
    localparam int MASK_W      = 16;
    localparam int PITCH_W     = 7;
    localparam int PITCH_COUNT = 100;
    localparam int SLOT_W      = $clog2(PITCH_COUNT);
    localparam int CFG_W       = 5;

    localparam logic signed [PITCH_W-1:0] PITCH_MIN = -7'sd50;
    localparam logic signed [PITCH_W-1:0] PITCH_MAX = 7'sd49;
    localparam logic signed [PITCH_W:0]   SLOT_OFS  = 8'sd50;

    localparam logic [CFG_W-1:0] VIU_RESET = 5'd8;

    typedef logic [1:0] t_action;
    localparam t_action ACT_NONE    = 2'd0;
    localparam t_action ACT_KEYDOWN = 2'd1;
    localparam t_action ACT_RELEASE = 2'd2;

    localparam logic FUNC_DOWN = 1'b0;
    localparam logic FUNC_UP   = 1'b1;

    // Result of the round-robin search.
    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [VOICE_W-1:0] next_ptr;
    } t_pick;

endpackage

[rtl/pva_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pva_search.sv]
// Round-robin search for the first idle voice starting at the rotate pointer.
// Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_search (
    input  logic [pva_pkg::MASK_W-1:0]  i_idle_mask,
    input  logic [pva_pkg::VOICE_W-1:0] i_ptr,
    input  logic [pva_pkg::CNT_W-1:0]   i_count,
    output pva_pkg::t_pick              o_pick
);

    logic [pva_pkg::CNT_W-1:0]   ptr_eff;
    logic [pva_pkg::CNT_W-1:0]   idx [pva_pkg::MAX_VOICES];
    logic [pva_pkg::MAX_VOICES-1:0] cand;
    logic [pva_pkg::CNT_W-1:0]   ptr_inc;
    logic [pva_pkg::VOICE_W-1:0] chosen;

    always_comb begin
        ptr_eff = ({1'b0, i_ptr} >= i_count) ? '0 : {1'b0, i_ptr};
        for (int j = 0; j < pva_pkg::MAX_VOICES; j++) begin
            idx[j] = ptr_eff + pva_pkg::CNT_W'(j);
            if (idx[j] >= i_count) begin
                idx[j] = idx[j] - i_count;
            end
            // Voices past the mask width always count as busy.
            cand[j] = (pva_pkg::CNT_W'(j) < i_count)
                      && (int'(idx[j]) < pva_pkg::MASK_W)
                      && i_idle_mask[idx[j][pva_pkg::VOICE_W-1:0]];
        end
        // With no idle voice the pointer's own voice is taken.
        chosen = ptr_eff[pva_pkg::VOICE_W-1:0];
        for (int j = pva_pkg::MAX_VOICES - 1; j >= 0; j--) begin
            if (cand[j]) begin
                chosen = idx[j][pva_pkg::VOICE_W-1:0];
            end
        end
        ptr_inc = ptr_eff + 1'b1;
        o_pick.voice    = chosen;
        o_pick.next_ptr = (ptr_inc == i_count) ? '0 : ptr_inc[pva_pkg::VOICE_W-1:0];
    end

endmodule

[rtl/pva_ctrl.sv]
// Sequencer, pitch and owner tables, rotate pointer and output register.
// Depends on pva_pkg, pva_ram and pva_search.
`timescale 1ns / 1ps

module pva_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [pva_pkg::CNT_W-1:0]          i_count,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic signed [pva_pkg::PITCH_W-1:0] i_pitch,
    input  logic [pva_pkg::MASK_W-1:0]         i_idle_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pva_pkg::t_action                   o_action,
    output logic [pva_pkg::VOICE_W-1:0]        o_voice,
    output logic                               o_newly_assigned
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RDMAP  = 2'd1;
    localparam logic [1:0] ST_RDOWN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic                             r_func;
    logic                             r_inrange;
    logic [pva_pkg::SLOT_W-1:0]       r_slot;
    logic [pva_pkg::MASK_W-1:0]       r_mask;
    logic [pva_pkg::VOICE_W-1:0]      r_voice;
    logic [pva_pkg::VOICE_W-1:0]      r_ptr, n_ptr;
    logic [pva_pkg::MAX_VOICES-1:0]   r_owner_vld, n_owner_vld;
    logic [pva_pkg::PITCH_COUNT-1:0]  r_slot_used, n_slot_used;
    logic                             r_out_vld, n_out_vld;
    pva_pkg::t_action                 r_action, n_action;
    logic [pva_pkg::VOICE_W-1:0]      r_ovoice, n_ovoice;
    logic                             r_fresh, n_fresh;

    logic                             accept;
    logic                             out_free;
    logic                             inrange;
    logic signed [pva_pkg::PITCH_W:0] slot_sum;
    logic [pva_pkg::VOICE_W-1:0]      map_q;
    logic [pva_pkg::SLOT_W-1:0]       own_q;
    logic [pva_pkg::VOICE_W-1:0]      own_raddr;
    logic                             assigned;
    logic                             alloc_we;
    pva_pkg::t_pick                   pick;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_vld || !i_out_stall;

    assign inrange  = (i_pitch >= pva_pkg::PITCH_MIN) && (i_pitch <= pva_pkg::PITCH_MAX);
    assign slot_sum = {i_pitch[pva_pkg::PITCH_W-1], i_pitch} + pva_pkg::SLOT_OFS;

    // Pitch table: voice index per pitch slot. A slot counts only once it has
    // been written and the owner table points back at the same slot.
    pva_ram #(
        .WIDTH(pva_pkg::VOICE_W),
        .DEPTH(pva_pkg::PITCH_COUNT)
    ) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (alloc_we),
        .i_waddr(r_slot),
        .i_wdata(pick.voice),
        .i_raddr(r_slot),
        .o_rdata(map_q)
    );

    // Owner table: the pitch slot that currently holds each voice.
    assign own_raddr = (r_state == ST_RDOWN) ? map_q : r_voice;

    pva_ram #(
        .WIDTH(pva_pkg::SLOT_W),
        .DEPTH(pva_pkg::MAX_VOICES)
    ) u_own_ram (
        .i_clk  (i_clk),
        .i_we   (alloc_we),
        .i_waddr(pick.voice),
        .i_wdata(r_slot),
        .i_raddr(own_raddr),
        .o_rdata(own_q)
    );

    pva_search u_search (
        .i_idle_mask(r_mask),
        .i_ptr      (r_ptr),
        .i_count    (i_count),
        .o_pick     (pick)
    );

    assign assigned = r_slot_used[r_slot] && r_owner_vld[r_voice] && (own_q == r_slot);
    assign alloc_we = (r_state == ST_DECIDE) && out_free && r_inrange
                      && (r_func == pva_pkg::FUNC_DOWN) && !assigned;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_owner_vld = r_owner_vld;
        n_slot_used = r_slot_used;
        n_out_vld   = r_out_vld;
        n_action    = r_action;
        n_ovoice    = r_ovoice;
        n_fresh     = r_fresh;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RDMAP;
                end
            end
            ST_RDMAP: begin
                n_state = ST_RDOWN;
            end
            ST_RDOWN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    n_action  = pva_pkg::ACT_NONE;
                    n_ovoice  = '0;
                    n_fresh   = 1'b0;
                    priority if (!r_inrange) begin
                        n_action = pva_pkg::ACT_NONE;
                    end else if (r_func == pva_pkg::FUNC_UP) begin
                        if (assigned) begin
                            n_action = pva_pkg::ACT_RELEASE;
                            n_ovoice = r_voice;
                        end
                    end else if (assigned) begin
                        if (r_mask[r_voice]) begin
                            n_action = pva_pkg::ACT_KEYDOWN;
                            n_ovoice = r_voice;
                        end
                    end else begin
                        n_action = pva_pkg::ACT_KEYDOWN;
                        n_ovoice = pick.voice;
                        n_fresh  = 1'b1;
                        n_ptr    = pick.next_ptr;
                        n_owner_vld[pick.voice] = 1'b1;
                        n_slot_used[r_slot]     = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_owner_vld <= '0;
            r_slot_used <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_owner_vld <= n_owner_vld;
            r_slot_used <= n_slot_used;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_ovoice <= n_ovoice;
        r_fresh  <= n_fresh;
        if (accept) begin
            r_func    <= i_func;
            r_inrange <= inrange;
            r_slot    <= inrange ? slot_sum[pva_pkg::SLOT_W-1:0] : '0;
            r_mask    <= i_idle_mask;
        end
        if (r_state == ST_RDOWN) begin
            r_voice <= map_q;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_action         = r_action;
    assign o_voice          = r_ovoice;
    assign o_newly_assigned = r_fresh;

endmodule

[rtl/polyphonic_voice_allocator_top.sv]
// Top level of the polyphonic voice allocator: configuration register and core.
// Depends on pva_pkg and pva_ctrl (which uses pva_ram and pva_search).
//
//   Channel   Direction  Handshake                 Payload
//   in        into block i_in_valid / o_in_stall   i_func, i_pitch, i_idle_mask
//   out       from block o_out_valid / i_out_stall o_action, o_voice, o_newly_assigned
//   cfg       into block i_cfg_valid / o_cfg_ready i_cfg_voices_in_use
//
// Every key event passes through the transfer, a read of the pitch table,
// a read of the owner table, and a decision step that writes both tables on a new assignment.
// The two table reads are dependent, so one event is in flight at a time.
// Reset needs no clearing pass; reset clears a flag per pitch that marks the
// pitches ever given a voice, and such a pitch counts as assigned only when
// the owner table, whose per-voice valid bits reset also clears, points back.
// A stalled output holds the decision cycle until the output register frees.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic signed [pva_pkg::PITCH_W-1:0] i_pitch,
    input  logic [pva_pkg::MASK_W-1:0]         i_idle_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_action,
    output logic [pva_pkg::VOICE_W-1:0]        o_voice,
    output logic                               o_newly_assigned,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pva_pkg::CFG_W-1:0]          i_cfg_voices_in_use
);

    logic [pva_pkg::CFG_W-1:0] r_voices_in_use;
    logic [pva_pkg::CNT_W-1:0] count;

    // The register takes a transfer in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voices_in_use <= pva_pkg::VIU_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_voices_in_use <= i_cfg_voices_in_use;
        end
    end

    // Effective voice count: zero acts as one, and values past the voice
    // limit act as the limit.
    always_comb begin
        priority if (r_voices_in_use == '0) begin
            count = pva_pkg::CNT_W'(1);
        end else if (int'(r_voices_in_use) > pva_pkg::MAX_VOICES) begin
            count = pva_pkg::CNT_W'(pva_pkg::MAX_VOICES);
        end else begin
            count = pva_pkg::CNT_W'(r_voices_in_use);
        end
    end

    pva_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_count         (count),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_pitch         (i_pitch),
        .i_idle_mask     (i_idle_mask),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action        (o_action),
        .o_voice         (o_voice),
        .o_newly_assigned(o_newly_assigned)
    );

endmodule

[rtl/pva_chk.sv]
// Port-level checker for the polyphonic voice allocator and its bind.
// Depends on pva_pkg and polyphonic_voice_allocator_top.
`timescale 1ns / 1ps

module pva_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_action,
    input logic [pva_pkg::VOICE_W-1:0] o_voice,
    input logic                        o_newly_assigned
);

    // A result waiting under stall stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // One event at a time: after an input transfer the input stalls.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an event is in flight");

    // A no-action result carries voice zero and no fresh flag.
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == pva_pkg::ACT_NONE) |-> (o_voice == '0) && !o_newly_assigned)
        else $error("no-action result carries payload");

    // A fresh assignment is always a key-down.
    a_fresh_keydown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_newly_assigned |-> (o_action == pva_pkg::ACT_KEYDOWN))
        else $error("fresh flag on a non key-down result");

endmodule

bind polyphonic_voice_allocator_top pva_chk u_pva_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_action        (o_action),
    .o_voice         (o_voice),
    .o_newly_assigned(o_newly_assigned)
);

[tb/sv/voice_alloc_checker.sv]
// Checker for the polyphonic voice allocator: tracks the pitch table and the
// round-robin pointer, predicts each result and compares it. Depends on pva_pkg.
`timescale 1ns / 1ps

module voice_alloc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               i_func,
    input  logic signed [pva_pkg::PITCH_W-1:0] i_pitch,
    input  logic [pva_pkg::MASK_W-1:0]         i_idle_mask,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic [1:0]                         o_action,
    input  logic [pva_pkg::VOICE_W-1:0]        o_voice,
    input  logic                               o_newly_assigned,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [pva_pkg::CFG_W-1:0]          i_cfg_voices_in_use,
    output int                                 o_mismatch_count,
    output int                                 o_pending
);
    import pva_pkg::*;

    typedef struct packed {
        t_action            action;
        logic [VOICE_W-1:0] voice;
        logic               fresh;
    } t_voice_cmd;

    logic               slot_held [PITCH_COUNT];
    logic [VOICE_W-1:0] slot_voice [PITCH_COUNT];
    logic [VOICE_W-1:0] rr_ptr;
    logic [CFG_W-1:0]   voice_count;
    t_voice_cmd         expected_cmds [$];
    int                 mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    function automatic t_voice_cmd decide_voice(
        input logic                      func,
        input logic signed [PITCH_W-1:0] pitch,
        input logic [MASK_W-1:0]         idle
    );
        t_voice_cmd cmd;
        int         pv;
        int         slot;
        int         n;
        int         ptr;
        int         cand;
        int         chosen;
        bit         found;
        cmd.action = ACT_NONE;
        cmd.voice  = '0;
        cmd.fresh  = 1'b0;
        pv = pitch;
        if (pv < PITCH_MIN || pv > PITCH_MAX) return cmd;
        slot = pv - PITCH_MIN;
        if (func == FUNC_UP) begin
            if (slot_held[slot]) begin
                cmd.action = ACT_RELEASE;
                cmd.voice  = slot_voice[slot];
            end
        end else if (slot_held[slot]) begin
            // An assigned pitch only retriggers when its voice has gone idle.
            if (idle[slot_voice[slot]]) begin
                cmd.action = ACT_KEYDOWN;
                cmd.voice  = slot_voice[slot];
            end
        end else begin
            n = voice_count;
            if (n < 1) n = 1;
            if (n > MAX_VOICES) n = MAX_VOICES;
            ptr = rr_ptr;
            if (ptr >= n) ptr = 0;
            chosen = ptr;
            cand   = ptr;
            found  = 1'b0;
            for (int j = 0; j < n && !found; j++) begin
                if (idle[cand]) begin
                    found  = 1'b1;
                    chosen = cand;
                end else begin
                    cand = (cand + 1 == n) ? 0 : cand + 1;
                end
            end
            rr_ptr = VOICE_W'((ptr + 1 == n) ? 0 : ptr + 1);
            // The chosen voice is taken away from whichever pitch held it.
            for (int k = 0; k < PITCH_COUNT; k++) begin
                if (k != slot && slot_held[k] && slot_voice[k] == chosen) slot_held[k] = 1'b0;
            end
            slot_held[slot]  = 1'b1;
            slot_voice[slot] = VOICE_W'(chosen);
            cmd.action = ACT_KEYDOWN;
            cmd.voice  = VOICE_W'(chosen);
            cmd.fresh  = 1'b1;
        end
        return cmd;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_voice_cmd want;
        if (!i_rst_n) begin
            voice_count = VIU_RESET;
            rr_ptr      = '0;
            for (int k = 0; k < PITCH_COUNT; k++) begin
                slot_held[k]  = 1'b0;
                slot_voice[k] = '0;
            end
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) voice_count = i_cfg_voices_in_use;
            if (i_in_valid && !o_in_stall) begin
                expected_cmds.push_back(decide_voice(i_func, i_pitch, i_idle_mask));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, o_action, o_voice, o_newly_assigned);
                    mismatch_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("action", want.action, o_action);
                    check_field("voice", want.voice, o_voice);
                    check_field("newly_assigned", want.fresh, o_newly_assigned);
                end
            end
        end
        o_pending <= expected_cmds.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for polyphonic_voice_allocator_top: clock, reset, key events,
// voice-count writes and the verdict. Depends on pva_pkg, the DUT, voice_alloc_checker.
`timescale 1ns / 1ps

module tb_top;
    import pva_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int POOL_SIZE       = 12;

    // Voice count per phase. Phase 0 runs on the reset value; the later ones
    // raise and lower the count so that stale pointers and stale assignments
    // occur, and they include zero and the top of the 5-bit register.
    localparam logic [CFG_W-1:0] COUNT_PLAN [PHASES] = '{
        5'd8, 5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd12, 5'd5
    };

    logic                        i_clk;
    logic                        i_rst_n             = 1'b0;
    logic                        i_in_valid          = 1'b0;
    logic                        o_in_stall;
    logic                        i_func              = FUNC_DOWN;
    logic signed [PITCH_W-1:0]   i_pitch             = '0;
    logic [MASK_W-1:0]           i_idle_mask         = '0;
    logic                        o_out_valid;
    logic                        i_out_stall         = 1'b0;
    logic [1:0]                  o_action;
    logic [VOICE_W-1:0]          o_voice;
    logic                        o_newly_assigned;
    logic                        i_cfg_valid         = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_W-1:0]            i_cfg_voices_in_use = '0;

    int                          mismatch_count;
    int                          pending;
    int                          in_gap_pct          = 0;
    int                          out_stall_pct       = 0;
    logic signed [PITCH_W-1:0]   pitch_pool [POOL_SIZE];

    polyphonic_voice_allocator_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_pitch             (i_pitch),
        .i_idle_mask         (i_idle_mask),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_action            (o_action),
        .o_voice             (o_voice),
        .o_newly_assigned    (o_newly_assigned),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_voices_in_use (i_cfg_voices_in_use)
    );

    // The checker sits beside the block, watches all three channels and
    // reports how many results are still owed and how many were wrong.
    voice_alloc_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_pitch             (i_pitch),
        .i_idle_mask         (i_idle_mask),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_action            (o_action),
        .o_voice             (o_voice),
        .o_newly_assigned    (o_newly_assigned),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_voices_in_use (i_cfg_voices_in_use),
        .o_mismatch_count    (mismatch_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, one decision per clock, so stalls land
    // on every state of the event sequencer.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // One key event transfer. Optional idle cycles come first; valid then
    // stays high until the block stops stalling. Valid is left high on
    // return, so a following event is presented back to back without a
    // drop of valid in between.
    task automatic send_key_event(
        input logic                      func,
        input logic signed [PITCH_W-1:0] pitch,
        input logic [MASK_W-1:0]         idle
    );
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_pitch     <= pitch;
        i_idle_mask <= idle;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Most events reuse a small set of pitches so that assignments, steals,
    // retriggers and releases keep happening; the rest hit any legal pitch
    // or one outside the keyboard range. Idle masks lean toward the corners
    // (none idle, all idle, sparse) where the search behaves differently.
    task automatic send_random_event();
        int                        sel;
        int                        v;
        logic                      func;
        logic signed [PITCH_W-1:0] pitch;
        logic [MASK_W-1:0]         idle;
        func = ($urandom_range(99) < 60) ? FUNC_DOWN : FUNC_UP;
        sel = $urandom_range(99);
        if (sel < 70) begin
            pitch = pitch_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (sel < 90) begin
            v = int'($urandom_range(99)) - 50;
            pitch = PITCH_W'(v);
        end else begin
            v = $urandom_range(27);
            v = (v < 14) ? v - 64 : v + 36;
            pitch = PITCH_W'(v);
        end
        sel = $urandom_range(99);
        if (sel < 10)      idle = '0;
        else if (sel < 20) idle = '1;
        else if (sel < 50) idle = MASK_W'($urandom_range(65535) & $urandom_range(65535));
        else               idle = MASK_W'($urandom_range(65535));
        send_key_event(func, pitch, idle);
    endtask

    // Voice count writes happen only with no event in flight.
    task automatic write_voice_count(input logic [CFG_W-1:0] count);
        i_cfg_valid         <= 1'b1;
        i_cfg_voices_in_use <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Every event yields exactly one result, so once the checker owes nothing
    // the block is idle again.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int v;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) write_voice_count(COUNT_PLAN[phase]);

            // Sender busy and receiver slow, then the reverse, then full rate.
            if (phase < 3) begin
                in_gap_pct    = 30;
                out_stall_pct = 52;
            end else if (phase < 6) begin
                in_gap_pct    = 52;
                out_stall_pct = 30;
            end else begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end

            for (int k = 0; k < POOL_SIZE; k++) begin
                v = int'($urandom_range(99)) - 50;
                pitch_pool[k] = PITCH_W'(v);
            end

            if (phase == 0) begin
                // Eight voices, pointer at zero. No voice idle: the pointer's
                // voice is taken.
                send_key_event(FUNC_DOWN, PITCH_MIN, 16'h0000);
                // Everything idle: the search starts at the pointer.
                send_key_event(FUNC_DOWN, PITCH_MAX, 16'hFFFF);
                // The pitch's voice is busy, so nothing happens.
                send_key_event(FUNC_DOWN, PITCH_MIN, 16'h0000);
                // Its voice is idle again, so it is retriggered.
                send_key_event(FUNC_DOWN, PITCH_MIN, 16'h0001);
                send_key_event(FUNC_UP, PITCH_MIN, 16'h0000);
                // Release of a pitch that never had a voice.
                send_key_event(FUNC_UP, 7'sd0, 16'hFFFF);
                // Only a voice above the active count is idle; it must not
                // be picked.
                send_key_event(FUNC_DOWN, 7'sd0, 16'h8000);
                // The search wraps around to voice 0 and steals it from the
                // lowest pitch, whose release then does nothing.
                send_key_event(FUNC_DOWN, 7'sd1, 16'h0001);
                send_key_event(FUNC_UP, PITCH_MIN, 16'hFFFF);
                send_key_event(FUNC_UP, 7'sd1, 16'hFFFF);
                // Pitches just outside and at the far ends of the field.
                send_key_event(FUNC_DOWN, -7'sd51, 16'hFFFF);
                send_key_event(FUNC_DOWN, 7'sd50, 16'hFFFF);
                send_key_event(FUNC_DOWN, 7'sh40, 16'hFFFF);
                send_key_event(FUNC_UP, 7'sd63, 16'h0000);
                send_key_event(FUNC_UP, 7'sh40, 16'h5555);
                send_key_event(FUNC_DOWN, 7'sd48, 16'hAAAA);
            end

            repeat (ITEMS_PER_PHASE) send_random_event();
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("PASS polyphonic_voice_allocator_top");
        end else begin
            $display("FAIL polyphonic_voice_allocator_top");
        end
        $finish;
    end

    // Watchdog: a run that hangs is reported as a failure.
    initial begin
        #2_000_000;
        $display("FAIL polyphonic_voice_allocator_top");
        $finish;
    end

endmodule

[filelist.f]
rtl/pva_pkg.sv
rtl/pva_ram.sv
rtl/pva_search.sv
rtl/pva_ctrl.sv
rtl/polyphonic_voice_allocator_top.sv
rtl/pva_chk.sv
tb/sv/voice_alloc_checker.sv
tb/sv/tb_top.sv
